@@ hdl/rpn_stack_evaluator_defines.svh @@
// ----------------------------------------------------------------------------
// rpn stack evaluator assertion macros
// shared concurrent assertion forms, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef RPN_STACK_EVALUATOR_DEFINES_SVH
`define RPN_STACK_EVALUATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define RPN_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpn assertion failed");
`define RPN_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpn assertion failed");
`else
`define RPN_ASSERT_IMP(label, ante, cons)
`define RPN_ASSERT_NXT(label, ante, cons)
`endif

`endif

@@ hdl/rpn_pkg.sv @@
// ----------------------------------------------------------------------------
// rpn package
// constants, codes, command and status types of the rpn stack evaluator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rpn_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DATA_W      = 32;
    localparam int DIV_CNT_W   = $clog2(DATA_W);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_NL    = 8'h0A;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FEW  = 2'd1,
        ST_OVER = 2'd2,
        ST_DIV0 = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CC_DIGIT,
        CC_OP,
        CC_NEWLINE,
        CC_OTHER
    } char_class_t;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } op_t;

    typedef enum logic [1:0] {
        RES_ALU,
        RES_DIV,
        RES_TOP,
        RES_ZERO
    } res_src_t;

    typedef enum logic {
        RD_TOP,
        RD_SECOND
    } rd_sel_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_A,
        S_EXEC,
        S_DIV,
        S_WRITE,
        S_NL,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     push;
        logic     wb;
        logic     sp_clear;
        logic     skip_set;
        logic     skip_clear;
        logic     op_load;
        logic     b_load;
        logic     div_start;
        logic     res_load;
        res_src_t res_src;
        status_t  res_status;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic sp_zero;
        logic sp_lt2;
        logic sp_full;
        logic skip;
        logic b_zero;
        logic op_div;
        logic div_done;
        logic out_free;
    } stat_t;

    function automatic char_class_t char_class(input logic [7:0] c);
        char_class_t cls;
        case (c) inside
            [CH_ZERO:CH_NINE]:                     cls = CC_DIGIT;
            CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH:  cls = CC_OP;
            CH_NL:                                 cls = CC_NEWLINE;
            default:                               cls = CC_OTHER;
        endcase
        return cls;
    endfunction

    function automatic op_t char_op(input logic [7:0] c);
        op_t op;
        case (c)
            CH_MINUS: op = OP_SUB;
            CH_STAR:  op = OP_MUL;
            CH_SLASH: op = OP_DIV;
            default:  op = OP_ADD;
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

@@ hdl/rpn_divider.sv @@
// ----------------------------------------------------------------------------
// rpn divider
// radix-2 restoring signed divider, one quotient bit per cycle, truncating
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpn_divider (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [rpn_pkg::DATA_W-1:0]    dividend,
    input  wire logic [rpn_pkg::DATA_W-1:0]    divisor,
    output logic                               done,
    output logic [rpn_pkg::DATA_W-1:0]         quotient
);

    localparam int W = rpn_pkg::DATA_W;

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [rpn_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          neg_reg, neg_next;
    logic [W-1:0]                  rem_reg, rem_next;
    logic [W-1:0]                  quo_reg, quo_next;
    logic [W-1:0]                  dvs_reg, dvs_next;
    logic [W:0]                    shifted;
    logic [W:0]                    diff;

    assign shifted = {rem_reg, quo_reg[W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = dividend[W-1] ^ divisor[W-1];
            rem_next  = '0;
            quo_next  = dividend[W-1] ? (W'(0) - dividend) : dividend;
            dvs_next  = divisor[W-1] ? (W'(0) - divisor) : divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == rpn_pkg::DIV_CNT_W'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (W'(0) - quo_reg) : quo_reg;

endmodule

`default_nettype wire

@@ hdl/rpn_datapath.sv @@
// ----------------------------------------------------------------------------
// rpn datapath
// operand stack memory, stack pointer, alu, divider and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpn_datapath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [7:0]                  char_code,
    input  wire rpn_pkg::cmd_t               cmd,
    output rpn_pkg::stat_t                   stat,
    input  wire logic                        out_ready,
    output logic                             out_valid,
    output logic signed [rpn_pkg::DATA_W-1:0] value,
    output logic [1:0]                       status
);

    localparam int W = rpn_pkg::DATA_W;

    logic [W-1:0]                   stack_mem [rpn_pkg::STACK_DEPTH];
    logic [rpn_pkg::SP_W-1:0]       sp_reg, sp_next;
    logic                           skip_reg, skip_next;
    logic                           out_valid_reg, out_valid_next;
    logic [W-1:0]                   rd_data_reg;
    logic [W-1:0]                   b_reg;
    rpn_pkg::op_t                   op_reg;
    logic [W-1:0]                   res_value_reg;
    rpn_pkg::status_t               res_status_reg;
    logic [W-1:0]                   value_reg;
    rpn_pkg::status_t               status_reg;
    logic [rpn_pkg::SP_W-1:0]       sp_m1, sp_m2;
    logic [rpn_pkg::ADDR_W-1:0]     rd_addr, wr_addr;
    logic [W-1:0]                   wr_data;
    logic [7:0]                     digit;
    logic [W-1:0]                   alu_result;
    logic [W-1:0]                   res_value_next;
    logic                           div_done;
    logic [W-1:0]                   div_quotient;
    logic                           out_free;

    assign sp_m1   = sp_reg - rpn_pkg::SP_W'(1);
    assign sp_m2   = sp_reg - rpn_pkg::SP_W'(2);
    assign rd_addr = (cmd.rd_sel == rpn_pkg::RD_TOP) ? sp_m1[rpn_pkg::ADDR_W-1:0]
                                                     : sp_m2[rpn_pkg::ADDR_W-1:0];
    assign wr_addr = cmd.push ? sp_reg[rpn_pkg::ADDR_W-1:0] : sp_m2[rpn_pkg::ADDR_W-1:0];
    assign digit   = char_code - rpn_pkg::CH_ZERO;
    assign wr_data = cmd.push ? {{(W-8){1'b0}}, digit} : res_value_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.push || cmd.wb)
        begin
            stack_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    rpn_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rd_data_reg),
        .divisor  (b_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        case (op_reg)
            rpn_pkg::OP_SUB: alu_result = rd_data_reg - b_reg;
            rpn_pkg::OP_MUL: alu_result = rd_data_reg * b_reg;
            default:         alu_result = rd_data_reg + b_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.res_src)
            rpn_pkg::RES_ALU: res_value_next = alu_result;
            rpn_pkg::RES_DIV: res_value_next = div_quotient;
            rpn_pkg::RES_TOP: res_value_next = rd_data_reg;
            default:          res_value_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op_load)
        begin
            op_reg <= rpn_pkg::char_op(char_code);
        end
        if (cmd.b_load)
        begin
            b_reg <= rd_data_reg;
        end
        if (cmd.res_load)
        begin
            res_value_reg  <= res_value_next;
            res_status_reg <= cmd.res_status;
        end
        if (cmd.out_load)
        begin
            value_reg  <= res_value_reg;
            status_reg <= res_status_reg;
        end
    end

    always_comb
    begin
        sp_next = sp_reg;
        if (cmd.sp_clear)
        begin
            sp_next = '0;
        end
        else if (cmd.push)
        begin
            sp_next = sp_reg + rpn_pkg::SP_W'(1);
        end
        else if (cmd.wb)
        begin
            sp_next = sp_m1;
        end

        skip_next = skip_reg;
        if (cmd.skip_set)
        begin
            skip_next = 1'b1;
        end
        else if (cmd.skip_clear)
        begin
            skip_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg        <= '0;
            skip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sp_reg        <= sp_next;
            skip_reg      <= skip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    assign stat.sp_zero  = (sp_reg == '0);
    assign stat.sp_lt2   = (sp_reg < rpn_pkg::SP_W'(2));
    assign stat.sp_full  = (sp_reg >= rpn_pkg::SP_W'(rpn_pkg::STACK_DEPTH));
    assign stat.skip     = skip_reg;
    assign stat.b_zero   = (b_reg == '0);
    assign stat.op_div   = (op_reg == rpn_pkg::OP_DIV);
    assign stat.div_done = div_done;
    assign stat.out_free = out_free;

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

@@ hdl/rpn_controller.sv @@
// ----------------------------------------------------------------------------
// rpn controller
// state machine that decodes characters and sequences the datapath
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rpn_stack_evaluator_defines.svh"

module rpn_controller (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [7:0]     char_code,
    input  wire rpn_pkg::stat_t stat,
    output rpn_pkg::cmd_t       cmd
);

    rpn_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rpn_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            rpn_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (rpn_pkg::char_class(char_code))
                        rpn_pkg::CC_NEWLINE:
                        begin
                            cmd.sp_clear = 1'b1;
                            if (stat.skip)
                            begin
                                cmd.skip_clear = 1'b1;
                            end
                            else if (stat.sp_zero)
                            begin
                                cmd.res_load   = 1'b1;
                                cmd.res_src    = rpn_pkg::RES_ZERO;
                                cmd.res_status = rpn_pkg::ST_FEW;
                                state_next     = rpn_pkg::S_EMIT;
                            end
                            else
                            begin
                                cmd.sp_clear = 1'b0;
                                cmd.rd_en    = 1'b1;
                                cmd.rd_sel   = rpn_pkg::RD_TOP;
                                state_next   = rpn_pkg::S_NL;
                            end
                        end
                        rpn_pkg::CC_DIGIT:
                        begin
                            if (!stat.skip)
                            begin
                                if (stat.sp_full)
                                begin
                                    cmd.sp_clear   = 1'b1;
                                    cmd.skip_set   = 1'b1;
                                    cmd.res_load   = 1'b1;
                                    cmd.res_src    = rpn_pkg::RES_ZERO;
                                    cmd.res_status = rpn_pkg::ST_OVER;
                                    state_next     = rpn_pkg::S_EMIT;
                                end
                                else
                                begin
                                    cmd.push = 1'b1;
                                end
                            end
                        end
                        rpn_pkg::CC_OP:
                        begin
                            if (!stat.skip)
                            begin
                                if (stat.sp_lt2)
                                begin
                                    cmd.sp_clear   = 1'b1;
                                    cmd.skip_set   = 1'b1;
                                    cmd.res_load   = 1'b1;
                                    cmd.res_src    = rpn_pkg::RES_ZERO;
                                    cmd.res_status = rpn_pkg::ST_FEW;
                                    state_next     = rpn_pkg::S_EMIT;
                                end
                                else
                                begin
                                    cmd.op_load = 1'b1;
                                    cmd.rd_en   = 1'b1;
                                    cmd.rd_sel  = rpn_pkg::RD_TOP;
                                    state_next  = rpn_pkg::S_RD_A;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            rpn_pkg::S_RD_A:
            begin
                cmd.b_load = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = rpn_pkg::RD_SECOND;
                state_next = rpn_pkg::S_EXEC;
            end
            rpn_pkg::S_EXEC:
            begin
                if (stat.op_div)
                begin
                    if (stat.b_zero)
                    begin
                        cmd.sp_clear   = 1'b1;
                        cmd.skip_set   = 1'b1;
                        cmd.res_load   = 1'b1;
                        cmd.res_src    = rpn_pkg::RES_ZERO;
                        cmd.res_status = rpn_pkg::ST_DIV0;
                        state_next     = rpn_pkg::S_EMIT;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = rpn_pkg::S_DIV;
                    end
                end
                else
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_src  = rpn_pkg::RES_ALU;
                    state_next   = rpn_pkg::S_WRITE;
                end
            end
            rpn_pkg::S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_src  = rpn_pkg::RES_DIV;
                    state_next   = rpn_pkg::S_WRITE;
                end
            end
            rpn_pkg::S_WRITE:
            begin
                cmd.wb     = 1'b1;
                state_next = rpn_pkg::S_IDLE;
            end
            rpn_pkg::S_NL:
            begin
                cmd.sp_clear   = 1'b1;
                cmd.res_load   = 1'b1;
                cmd.res_src    = rpn_pkg::RES_TOP;
                cmd.res_status = rpn_pkg::ST_OK;
                state_next     = rpn_pkg::S_EMIT;
            end
            rpn_pkg::S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = rpn_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rpn_pkg::S_IDLE;
            end
        endcase
    end

    `RPN_ASSERT_IMP(a_out_load_free, cmd.out_load, stat.out_free)
    `RPN_ASSERT_IMP(a_wb_has_operands, cmd.wb, !stat.sp_lt2)
    `RPN_ASSERT_NXT(a_div_start_waits, cmd.div_start, state_reg == rpn_pkg::S_DIV)
    `RPN_ASSERT_NXT(a_div_done_writes, (state_reg == rpn_pkg::S_DIV) && stat.div_done,
                    state_reg == rpn_pkg::S_WRITE)

endmodule

`default_nettype wire

@@ hdl/rpn_stack_evaluator.sv @@
// ----------------------------------------------------------------------------
// rpn stack evaluator
// reverse polish notation evaluator on a 32-bit wrapping integer stack
// ----------------------------------------------------------------------------
// One ASCII character is taken per transaction. Digits push, + - * / combine
// the two top entries, newline emits the top entry with status ok and clears
// the stack; errors emit value zero with a status code and skip to the next
// newline. A digit or an ignored character is taken in the idle state; + - *
// read the two operands, execute and write back; a newline with a result
// reads the top entry, loads it and emits it; / waits in a divide state for
// the radix-2 divider that retires one quotient bit per cycle. Stack memory
// reads return registered data. A result sits in the output register, so the
// next character is taken while it waits; a second result waits until the
// first is taken. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpn_stack_evaluator (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [7:0]                   char_code,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [rpn_pkg::DATA_W-1:0] value,
    output logic [1:0]                        status
);

    rpn_pkg::cmd_t  cmd;
    rpn_pkg::stat_t stat;

    rpn_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_code (char_code),
        .stat      (stat),
        .cmd       (cmd)
    );

    rpn_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_code (char_code),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .value     (value),
        .status    (status)
    );

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// rpn stack evaluator testbench
// ----------------------------------------------------------------------------
// Characters are sent over the input valid/ready channel. A behavioral
// evaluator with its own operand stack predicts each result, and every
// result transaction is checked in order against those predictions. Directed
// tests cover each operator, signed division, wrap at the 32-bit limits,
// every error status, skip mode, ignored codes and the stack depth limit.
// Random expressions, broken sequences and noise follow under three idle
// settings. A long receiver hold-off fills the block so that it stalls its
// input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 60;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic signed [rpn_pkg::DATA_W-1:0] value;
        rpn_pkg::status_t                  status;
    } rpn_result_t;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              in_valid  = 1'b0;
    logic                              in_ready;
    logic [7:0]                        char_code = 8'h00;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    logic signed [rpn_pkg::DATA_W-1:0] value;
    logic [1:0]                        status;

    rpn_result_t                awaited_results [$];
    logic [rpn_pkg::DATA_W-1:0] model_stack [rpn_pkg::STACK_DEPTH];
    int                         model_depth    = 0;
    bit                         model_skipping = 1'b0;

    int                         send_idle_pct  = 26;
    int                         recv_stall_pct = 56;
    int                         hold_left      = 0;
    int                         live_chars     = 0;
    int                         mismatch_count = 0;
    int                         cycle_count    = 0;

    rpn_stack_evaluator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_code (char_code),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .status    (status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver, with a counted hold-off for backpressure
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("error at %0t ns: %s", $time, msg);
    endtask

    always @(posedge clk)
    begin : check_results
        rpn_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_results.size() == 0)
                report($sformatf("result with none pending: value %0d status %0d",
                                 value, status));
            else
            begin
                want = awaited_results.pop_front();
                if (value !== want.value)
                    report($sformatf("value expected %0d, got %0d", want.value, value));
                if (status !== want.status)
                    report($sformatf("status expected %0d, got %0d", want.status, status));
            end
        end
    end

    function automatic void expect_result(input logic [rpn_pkg::DATA_W-1:0] v,
                                          input rpn_pkg::status_t st);
        rpn_result_t r;
        r.value  = v;
        r.status = st;
        awaited_results.push_back(r);
    endfunction

    function automatic void raise_error(input rpn_pkg::status_t st);
        model_depth    = 0;
        model_skipping = 1'b1;
        expect_result('0, st);
    endfunction

    function automatic bit is_live_char(input logic [7:0] c);
        return (c >= rpn_pkg::CH_ZERO && c <= rpn_pkg::CH_NINE) ||
               c == rpn_pkg::CH_PLUS || c == rpn_pkg::CH_MINUS ||
               c == rpn_pkg::CH_STAR || c == rpn_pkg::CH_SLASH || c == rpn_pkg::CH_NL;
    endfunction

    // behavioral evaluator: updates the operand stack, queues any result
    function automatic void evaluate_char(input logic [7:0] c);
        logic [rpn_pkg::DATA_W-1:0] a, b, r, mag_a, mag_b;
        if (c == rpn_pkg::CH_NL)
        begin
            if (model_skipping)
                model_skipping = 1'b0;
            else if (model_depth == 0)
                expect_result('0, rpn_pkg::ST_FEW);
            else
                expect_result(model_stack[model_depth-1], rpn_pkg::ST_OK);
            model_depth = 0;
            return;
        end
        if (model_skipping)
            return;
        if (c >= rpn_pkg::CH_ZERO && c <= rpn_pkg::CH_NINE)
        begin
            if (model_depth >= rpn_pkg::STACK_DEPTH)
                raise_error(rpn_pkg::ST_OVER);
            else
            begin
                model_stack[model_depth] = {24'd0, c - rpn_pkg::CH_ZERO};
                model_depth++;
            end
            return;
        end
        if (c != rpn_pkg::CH_PLUS && c != rpn_pkg::CH_MINUS &&
            c != rpn_pkg::CH_STAR && c != rpn_pkg::CH_SLASH)
            return;
        if (model_depth < 2)
        begin
            raise_error(rpn_pkg::ST_FEW);
            return;
        end
        b = model_stack[model_depth-1];
        a = model_stack[model_depth-2];
        case (c)
            rpn_pkg::CH_PLUS:  r = a + b;
            rpn_pkg::CH_MINUS: r = a - b;
            rpn_pkg::CH_STAR:  r = a * b;
            default:
            begin
                if (b == '0)
                begin
                    raise_error(rpn_pkg::ST_DIV0);
                    return;
                end
                // truncate toward zero on magnitudes, most negative wraps
                mag_a = a[rpn_pkg::DATA_W-1] ? -a : a;
                mag_b = b[rpn_pkg::DATA_W-1] ? -b : b;
                r = mag_a / mag_b;
                if (a[rpn_pkg::DATA_W-1] ^ b[rpn_pkg::DATA_W-1])
                    r = -r;
            end
        endcase
        model_depth--;
        model_stack[model_depth-1] = r;
    endfunction

    task automatic send_char(input logic [7:0] c);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        evaluate_char(c);
        if (is_live_char(c))
            live_chars++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    function automatic logic [7:0] random_digit();
        return rpn_pkg::CH_ZERO + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] random_op();
        logic [7:0] c;
        case ($urandom_range(3))
            0:       c = rpn_pkg::CH_PLUS;
            1:       c = rpn_pkg::CH_MINUS;
            2:       c = rpn_pkg::CH_STAR;
            default: c = rpn_pkg::CH_SLASH;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] random_ignored();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (is_live_char(c));
        return c;
    endfunction

    // leaves the most negative value on top of the stack
    task automatic push_min_int();
        send_char("8");
        repeat (9)
            send_text("8*");
        send_text("2*");
    endtask

    task automatic test_operators();
        send_text("34+\n");
        send_text("34-\n");
        send_text("67*\n");
        send_text("93/\n");
        send_text("123\n");
        send_text("99*9*9*5-\n");
    endtask

    task automatic test_signed_division();
        send_text("702-/\n");
        send_text("07-2/\n");
        send_text("07-02-/\n");
        send_text("29/\n");
    endtask

    task automatic test_wrap_extremes();
        push_min_int();
        send_char(rpn_pkg::CH_NL);
        push_min_int();
        send_text("01-/1-\n");
    endtask

    task automatic test_error_status();
        send_text("+\n");
        send_text("5*\n");
        send_text("50/\n");
        send_text("\n");
        send_text("7\n");
    endtask

    task automatic test_skip_mode();
        send_text("5+");
        send_text("12+*9/0");
        send_char(8'hFF);
        send_char(rpn_pkg::CH_NL);
        send_text("8\n");
    endtask

    task automatic test_ignored_codes();
        send_char(8'h00);
        send_char("5");
        send_char(8'hFF);
        send_char("a");
        send_char(8'h80);
        send_char(" ");
        send_char(rpn_pkg::CH_NL);
    endtask

    task automatic test_stack_limits();
        repeat (rpn_pkg::STACK_DEPTH)
            send_char(random_digit());
        send_char(rpn_pkg::CH_NL);
        repeat (rpn_pkg::STACK_DEPTH + 1)
            send_char(random_digit());
        send_text("34+");
        send_char(rpn_pkg::CH_NL);
        send_char(rpn_pkg::CH_NL);
    endtask

    // well-formed expression with random content and a few stray codes
    task automatic send_expression(input int operands);
        int pushed = 0;
        int held   = 0;
        while (pushed < operands || held > 1)
        begin
            if (held >= 2 && (pushed == operands || $urandom_range(1) == 1))
            begin
                send_char(random_op());
                held--;
            end
            else
            begin
                send_char(random_digit());
                pushed++;
                held++;
            end
            if ($urandom_range(19) == 0)
                send_char(random_ignored());
        end
        send_char(rpn_pkg::CH_NL);
    endtask

    task automatic send_broken(input int n);
        int pick;
        repeat (n)
        begin
            pick = $urandom_range(15);
            if (pick < 10)
                send_char(random_digit());
            else if (pick < 14)
                send_char(random_op());
            else if (pick == 14)
                send_char(rpn_pkg::CH_NL);
            else
                send_char(random_ignored());
        end
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int n_chars);
        int start_count;
        int pick;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        start_count    = live_chars;
        while (live_chars - start_count < n_chars)
        begin
            pick = $urandom_range(99);
            if (pick < 78)
                send_expression($urandom_range(1, 8));
            else if (pick < 79)
            begin
                repeat ($urandom_range(rpn_pkg::STACK_DEPTH - 8, rpn_pkg::STACK_DEPTH + 4))
                    send_char(random_digit());
                send_char(rpn_pkg::CH_NL);
            end
            else if (pick < 90)
                send_broken($urandom_range(1, 6));
            else
                repeat ($urandom_range(1, 6))
                    send_char(8'($urandom_range(255)));
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 300;
        repeat (20)
        begin
            send_char(random_digit());
            if ($urandom_range(3) == 0)
                send_text("7/");
            send_char(rpn_pkg::CH_NL);
        end
    endtask

    initial
    begin
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_operators();
        test_signed_division();
        test_wrap_extremes();
        test_error_status();
        test_skip_mode();
        test_ignored_codes();
        test_stack_limits();
        test_random_traffic(26, 56, 310);
        test_random_traffic(56, 26, 310);
        test_random_traffic(0, 0, 310);
        test_backpressure();
        recv_stall_pct = 0;

        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
